// ===== hw/rtl/fhss_pkg.sv =====
// ----------------------------------------------------------------------------
// fhss_pkg
// Shared types and constants for the flow hash server select block.
// ----------------------------------------------------------------------------
package fhss_pkg;

  // Server table geometry
  localparam int TABLE_ENTRIES = 256;
  localparam int TBL_AW        = $clog2(TABLE_ENTRIES);
  localparam int MAC_W         = 48;

  // floor(2^32 / TABLE_ENTRIES), used for the hash-mod-table reduction
  localparam logic [31:0] TBL_RECIP = 32'(64'h1_0000_0000 / TABLE_ENTRIES);

  // Hash constants
  localparam logic [31:0] SEED_RESET = 32'd256;
  localparam logic [31:0] JH_INIT    = 32'hdead_beef;

  // Request kinds (tuser on the input side)
  localparam logic REQ_BYTE  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Verdict codes (tuser on the output side)
  localparam logic [1:0] VERDICT_DROP = 2'd0;
  localparam logic [1:0] VERDICT_PASS = 2'd1;
  localparam logic [1:0] VERDICT_XMIT = 2'd2;

  // Frame parsing
  localparam logic [5:0]  POS_MAX       = 6'd63;
  localparam logic [5:0]  OFS_ETYPE_HI  = 6'd12;
  localparam logic [5:0]  OFS_ETYPE_LO  = 6'd13;
  localparam logic [5:0]  OFS_PROTO     = 6'd23;
  localparam logic [5:0]  OFS_SRC       = 6'd26;
  localparam logic [5:0]  OFS_PORTS     = 6'd34;
  localparam logic [5:0]  LEN_ETH       = 6'd14;
  localparam logic [5:0]  LEN_IP        = 6'd34;
  localparam logic [5:0]  LEN_TCP       = 6'd54;
  localparam logic [5:0]  LEN_UDP       = 6'd42;
  localparam logic [15:0] ETYPE_IPV4    = 16'h0800;
  localparam logic [7:0]  PROTO_TCP     = 8'd6;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;

  // Frame summary handed from the parser to the hash pipeline
  typedef struct packed {
    logic [1:0]  verdict;
    logic [31:0] src;
    logic [31:0] ports;
  } frm_t;

  // Lookup request handed from the hash pipeline to the table stage
  typedef struct packed {
    logic [1:0]        verdict;
    logic [TBL_AW-1:0] slot;
  } lkp_t;

endpackage

// ===== hw/rtl/fhss_ram.sv =====
// ----------------------------------------------------------------------------
// fhss_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fhss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/fhss_parse.sv =====
// ----------------------------------------------------------------------------
// fhss_parse
// Byte-wise frame parser: tracks the byte position, captures the header
// fields and forms the verdict on the last byte of a frame.
// ----------------------------------------------------------------------------
module fhss_parse (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_en,
  input  logic [7:0]         byte_data,
  input  logic               byte_last,
  output fhss_pkg::frm_t     frm
);

  logic [5:0]  pos;
  logic [15:0] etype;
  logic [7:0]  proto;
  logic [31:0] src;
  logic [31:0] ports;

  logic [5:0]  pos_next;
  logic [15:0] etype_next;
  logic [7:0]  proto_next;
  logic [31:0] src_next;
  logic [31:0] ports_next;
  logic [1:0]  verdict;

  // Field capture for the current byte
  always_comb begin
    etype_next = etype;
    proto_next = proto;
    src_next   = src;
    ports_next = ports;
    if (pos == fhss_pkg::OFS_ETYPE_HI) etype_next[15:8] = byte_data;
    if (pos == fhss_pkg::OFS_ETYPE_LO) etype_next[7:0]  = byte_data;
    if (pos == fhss_pkg::OFS_PROTO)    proto_next       = byte_data;
    // source address and port word, little-endian lanes
    for (int k = 0; k < 4; k++) begin
      if (pos == fhss_pkg::OFS_SRC + 6'(k))   src_next[8*k +: 8]   = byte_data;
      if (pos == fhss_pkg::OFS_PORTS + 6'(k)) ports_next[8*k +: 8] = byte_data;
    end
    pos_next = (pos == fhss_pkg::POS_MAX) ? pos : pos + 6'd1;
  end

  // Verdict, frame length counts this byte
  always_comb begin
    if (pos_next < fhss_pkg::LEN_ETH) begin
      verdict = fhss_pkg::VERDICT_DROP;
    end else if (etype_next != fhss_pkg::ETYPE_IPV4) begin
      verdict = fhss_pkg::VERDICT_PASS;
    end else if (pos_next < fhss_pkg::LEN_IP) begin
      verdict = fhss_pkg::VERDICT_DROP;
    end else if (proto_next == fhss_pkg::PROTO_TCP) begin
      verdict = (pos_next < fhss_pkg::LEN_TCP) ? fhss_pkg::VERDICT_DROP
                                               : fhss_pkg::VERDICT_XMIT;
    end else if (proto_next == fhss_pkg::PROTO_UDP) begin
      verdict = (pos_next < fhss_pkg::LEN_UDP) ? fhss_pkg::VERDICT_DROP
                                               : fhss_pkg::VERDICT_XMIT;
    end else begin
      verdict = fhss_pkg::VERDICT_PASS;
    end
  end

  assign frm.verdict = verdict;
  assign frm.src     = src_next;
  assign frm.ports   = ports_next;

  // Frame state, cleared at the end of every frame
  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      etype <= '0;
      proto <= '0;
      src   <= '0;
      ports <= '0;
    end else if (byte_en) begin
      if (byte_last) begin
        pos   <= '0;
        etype <= '0;
        proto <= '0;
        src   <= '0;
        ports <= '0;
      end else begin
        pos   <= pos_next;
        etype <= etype_next;
        proto <= proto_next;
        src   <= src_next;
        ports <= ports_next;
      end
    end
  end

endmodule

// ===== hw/rtl/fhss_hash.sv =====
// ----------------------------------------------------------------------------
// fhss_hash
// Pipelined two-word Jenkins hash followed by reduction modulo the table
// size. Nine stages, each with its own valid bit and back-pressure.
// ----------------------------------------------------------------------------
module fhss_hash (
  input  logic              clk,
  input  logic              rst,
  input  logic [31:0]       seed,
  input  logic              in_valid,
  output logic              in_ready,
  input  fhss_pkg::frm_t    in_frm,
  output logic              out_valid,
  input  logic              out_ready,
  output fhss_pkg::lkp_t    out_lkp,
  output logic              busy
);

  localparam int AW   = fhss_pkg::TBL_AW;
  localparam int NSTG = 9;
  localparam logic [AW:0] TBL_N = (AW+1)'(fhss_pkg::TABLE_ENTRIES);

  function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
    rotl = (v << s) | (v >> (32 - s));
  endfunction

  function automatic logic [31:0] mix(input logic [31:0] dst, input logic [31:0] src,
                                      input int s);
    mix = (dst ^ src) - rotl(src, s);
  endfunction

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] rdy;
  logic [1:0]      vd [NSTG];

  // stage payloads
  logic [31:0] s0_w0, s0_w1;
  logic [31:0] s1_a, s1_b, s1_c;
  logic [31:0] s2_a, s2_b, s2_c;
  logic [31:0] s3_a, s3_b, s3_c;
  logic [31:0] s4_b, s4_c;
  logic [31:0] s5_h;
  logic [31:0] s6_h;
  logic [63:0] s6_prod;
  logic [AW:0] s7_r;
  logic [AW-1:0] s8_slot;

  // mixing round intermediates
  logic [31:0] init, c_m1, a_m2, b_m3, c_m4, a_m5, b_m6, h_m7;
  logic [31:0] q_est, r_full;

  always_comb begin
    init  = seed + fhss_pkg::JH_INIT + 32'd8;
    c_m1  = mix(s1_c, s1_b, 14);
    a_m2  = mix(s1_a, c_m1, 11);
    b_m3  = mix(s2_b, s2_a, 25);
    c_m4  = mix(s2_c, b_m3, 16);
    a_m5  = mix(s3_a, s3_c, 4);
    b_m6  = mix(s3_b, a_m5, 14);
    h_m7  = mix(s4_c, s4_b, 24);
    q_est = s6_prod[63:32];
    r_full = s6_h - 32'(q_est * 32'(fhss_pkg::TABLE_ENTRIES));
  end

  // Per-stage ready chain
  always_comb begin
    rdy[NSTG-1] = !vld[NSTG-1] || out_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[NSTG-1];
  assign out_lkp.verdict = vd[NSTG-1];
  assign out_lkp.slot    = s8_slot;
  assign busy      = |vld;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      for (int i = 1; i < NSTG; i++) begin
        if (rdy[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      vd[0] <= in_frm.verdict;
      s0_w0 <= in_frm.src;
      s0_w1 <= in_frm.ports;
    end
    for (int i = 1; i < NSTG; i++) begin
      if (rdy[i]) vd[i] <= vd[i-1];
    end
    // init
    if (rdy[1]) begin
      s1_a <= s0_w0 + init;
      s1_b <= s0_w1 + init;
      s1_c <= init;
    end
    // rounds 1-2
    if (rdy[2]) begin
      s2_a <= a_m2;
      s2_b <= s1_b;
      s2_c <= c_m1;
    end
    // rounds 3-4
    if (rdy[3]) begin
      s3_a <= s2_a;
      s3_b <= b_m3;
      s3_c <= c_m4;
    end
    // rounds 5-6
    if (rdy[4]) begin
      s4_b <= b_m6;
      s4_c <= s3_c;
    end
    // round 7
    if (rdy[5]) begin
      s5_h <= h_m7;
    end
    // quotient estimate by reciprocal
    if (rdy[6]) begin
      s6_h    <= s5_h;
      s6_prod <= 64'(s5_h) * 64'(fhss_pkg::TBL_RECIP);
    end
    // remainder, below twice the table size
    if (rdy[7]) begin
      s7_r <= r_full[AW:0];
    end
    // final correction
    if (rdy[8]) begin
      s8_slot <= (s7_r >= TBL_N) ? AW'(s7_r - TBL_N) : s7_r[AW-1:0];
    end
  end

endmodule

// ===== hw/rtl/flow_hash_server_select.sv =====
// ----------------------------------------------------------------------------
// flow_hash_server_select
// Per-frame L4 flow hash load balancer: parses IPv4 TCP/UDP frames byte by
// byte and picks a server MAC from a table indexed by the flow hash.
// ----------------------------------------------------------------------------
// Takes one input word per cycle, frame bytes and table writes alike, while
// a last byte finds room in the hash stages and no lookup holds off a write.
// The verdict for a frame passes through nine hash and reduction stages,
// then the registered table read that doubles as the output register. Every
// stage holds its own valid bit, so a stalled output only stops the stages
// behind it and middle bytes keep flowing. A table write is held off while
// any lookup is still ahead of the table read, also while the output stalls,
// so each frame sees the table as it stood at its last byte. The table powers
// up as all zeros through per-entry valid bits; no clearing pass is needed
// after reset.
module flow_hash_server_select (
  input  logic        clk,
  input  logic        rst,
  // configuration: hash_seed
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // packet_byte[7:0], entry_index[15:8], entry_mac[63:16]
  input  logic        s_axis_tlast,   // last_byte
  input  logic [0:0]  s_axis_tuser,   // req_type
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // new_dest_mac[47:0], server_index[55:48]
  output logic [1:0]  m_axis_tuser    // verdict
);

  localparam int AW  = fhss_pkg::TBL_AW;
  localparam int MW  = fhss_pkg::MAC_W;
  localparam int NTB = fhss_pkg::TABLE_ENTRIES;

  logic [31:0]          hash_seed;
  logic                 in_acc;
  logic                 is_write;
  logic                 byte_en;
  logic                 wr_en;
  logic                 hash_in_valid, hash_in_ready, hash_busy;
  logic                 hash_out_valid, out_rdy, rd_en;
  fhss_pkg::frm_t       frm;
  fhss_pkg::lkp_t       lkp;
  logic [MW-1:0]        rd_mac;
  logic [NTB-1:0]       tbl_vld;
  logic                 o_vld, o_ok;
  logic [1:0]           o_vd;
  logic [AW-1:0]        o_slot;
  logic [MW-1:0]        o_mac;

  // Seed register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_seed <= fhss_pkg::SEED_RESET;
    end else if (cfg_valid && cfg_ready) begin
      hash_seed <= cfg_data;
    end
  end

  // Input acceptance: last bytes need hash stage room, writes wait for lookups
  assign is_write = (s_axis_tuser[0] == fhss_pkg::REQ_WRITE);
  always_comb begin
    if (is_write) begin
      s_axis_tready = !hash_busy;
    end else if (s_axis_tlast) begin
      s_axis_tready = hash_in_ready;
    end else begin
      s_axis_tready = 1'b1;
    end
  end
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign byte_en       = in_acc && !is_write;
  assign hash_in_valid = byte_en && s_axis_tlast;
  assign wr_en         = in_acc && is_write && (32'(s_axis_tdata[15:8]) < 32'(NTB));

  fhss_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .byte_en   (byte_en),
    .byte_data (s_axis_tdata[7:0]),
    .byte_last (s_axis_tlast),
    .frm       (frm)
  );

  fhss_hash u_hash (
    .clk       (clk),
    .rst       (rst),
    .seed      (hash_seed),
    .in_valid  (hash_in_valid),
    .in_ready  (hash_in_ready),
    .in_frm    (frm),
    .out_valid (hash_out_valid),
    .out_ready (out_rdy),
    .out_lkp   (lkp),
    .busy      (hash_busy)
  );

  // Server table
  assign out_rdy = !o_vld || m_axis_tready;
  assign rd_en   = hash_out_valid && out_rdy;

  fhss_ram #(
    .WIDTH (MW),
    .DEPTH (NTB)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(s_axis_tdata[15:8])),
    .wr_data (s_axis_tdata[63:16]),
    .rd_en   (rd_en),
    .rd_addr (lkp.slot),
    .rd_data (rd_mac)
  );

  // Entry valid bits: unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      tbl_vld <= '0;
    end else if (wr_en) begin
      tbl_vld[AW'(s_axis_tdata[15:8])] <= 1'b1;
    end
  end

  // Output register, paired with the RAM read register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (out_rdy) begin
      o_vld <= hash_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      o_vd   <= lkp.verdict;
      o_slot <= lkp.slot;
      o_ok   <= tbl_vld[lkp.slot];
    end
  end

  assign o_mac         = o_ok ? rd_mac : '0;
  assign m_axis_tvalid = o_vld;
  assign m_axis_tuser  = o_vd;
  assign m_axis_tdata  = (o_vd == fhss_pkg::VERDICT_XMIT) ? {8'(o_slot), o_mac} : '0;

`ifndef NO_ASSERTIONS
  // table never changes under a lookup that has not read it yet
  a_write_interlock: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !hash_busy)
    else $error("table write while lookup in flight");

  // only transmit verdicts carry a MAC and slot
  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != fhss_pkg::VERDICT_XMIT) |-> m_axis_tdata == '0)
    else $error("payload on non-transmit verdict");

  // a held result must keep its RAM read data
  a_hold_read: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !rd_en)
    else $error("table read over a held result");
`endif

endmodule
